### rtl/tdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdf_pkg
// Types and constants shared by the terminal frame deframer modules.
// ----------------------------------------------------------------------------
package tdf_pkg;

  localparam int HEADER_BYTES = 36;
  localparam int COUNT_W      = 25;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 24;

  localparam logic [31:0] MAGIC_WORD   = 32'h5444_5257;
  localparam logic [15:0] VERSION_WORD = 16'd1;

  localparam logic [23:0] MAX_PAYLOAD_RESET = 24'd65536;
  localparam logic [15:0] DIR_INPUT_RESET   = 16'd0;
  localparam logic [15:0] DIR_OUTPUT_RESET  = 16'd1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_INPUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_OUTPUT  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // Status codes.
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TRUNCATED = 4'd1;
  localparam logic [3:0] ST_MAGIC     = 4'd2;
  localparam logic [3:0] ST_VERSION   = 4'd3;
  localparam logic [3:0] ST_DIRECTION = 4'd4;
  localparam logic [3:0] ST_NULL_ID   = 4'd5;
  localparam logic [3:0] ST_ZERO_SEQ  = 4'd6;
  localparam logic [3:0] ST_BAD_LEN   = 4'd7;
  localparam logic [3:0] ST_MISMATCH  = 4'd8;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  payload_byte;
    logic [15:0] direction;
    logic [63:0] request_id_high;
    logic [63:0] request_id_low;
    logic [63:0] sequence_number;
    logic [23:0] payload_length;
    logic [3:0]  status_code;
    logic        frame_done;
  } out_item_t;

  // Results produced by one accepted byte, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  item0;
    out_item_t  item1;
  } res_push_t;

endpackage

### rtl/tdf_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdf_parser
// Byte counter, header capture, header checks, configuration registers and result formation.
// ----------------------------------------------------------------------------
module tdf_parser import tdf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  in_item_t              in_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output res_push_t             push
);

  logic [COUNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [3:0]         first_error_r, first_error_nxt;
  logic               header_valid_r, header_valid_nxt;
  logic [23:0]        max_payload_r;
  logic [15:0]        dir_input_r;
  logic [15:0]        dir_output_r;

  logic [7:0] hdr_r [HEADER_BYTES];
  logic [7:0] hb    [HEADER_BYTES];

  logic [COUNT_W-1:0] pos, cnt_inc, pay_off;
  logic               in_header, last_hdr, pay_ok;
  logic [31:0]        magic, len32;
  logic [15:0]        version, dir;
  logic [63:0]        id_high, id_low, seq;
  logic [23:0]        len24;
  logic [3:0]         hdr_err, frame_err, status;
  logic [COUNT_W:0]   total;
  out_item_t          hdr_item, pay_item, st_item;
  logic               hdr_out;

  assign pos = byte_count_r;

  // The current byte is merged in so that the check on the last header byte
  // sees the complete header.
  always_comb begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      hb[i] = (pos == COUNT_W'(i)) ? in_item.frame_byte : hdr_r[i];
    end
  end

  assign magic   = {hb[3], hb[2], hb[1], hb[0]};
  assign version = {hb[5], hb[4]};
  assign dir     = {hb[7], hb[6]};
  assign id_high = {hb[8], hb[9], hb[10], hb[11], hb[12], hb[13], hb[14], hb[15]};
  assign id_low  = {hb[16], hb[17], hb[18], hb[19], hb[20], hb[21], hb[22], hb[23]};
  assign seq     = {hb[31], hb[30], hb[29], hb[28], hb[27], hb[26], hb[25], hb[24]};
  assign len24   = {hb[34], hb[33], hb[32]};
  assign len32   = {hb[35], len24};

  always_comb begin
    priority if (magic != MAGIC_WORD)                         hdr_err = ST_MAGIC;
    else if (version != VERSION_WORD)                         hdr_err = ST_VERSION;
    else if (dir != dir_input_r && dir != dir_output_r)       hdr_err = ST_DIRECTION;
    else if (id_high == 64'd0 && id_low == 64'd0)             hdr_err = ST_NULL_ID;
    else if (seq == 64'd0)                                    hdr_err = ST_ZERO_SEQ;
    else if (len32 == 32'd0 || len32 > {8'd0, max_payload_r}) hdr_err = ST_BAD_LEN;
    else                                                      hdr_err = ST_OK;
  end

  assign in_header = pos < COUNT_W'(HEADER_BYTES);
  assign last_hdr  = pos == COUNT_W'(HEADER_BYTES - 1);
  assign pay_off   = pos - COUNT_W'(HEADER_BYTES);
  assign pay_ok    = !in_header && header_valid_r && (pay_off < COUNT_W'(len24));
  assign cnt_inc   = (&pos) ? pos : pos + COUNT_W'(1);
  assign hdr_out   = last_hdr && (hdr_err == ST_OK);
  assign frame_err = last_hdr ? hdr_err : first_error_r;
  assign total     = (COUNT_W+1)'(HEADER_BYTES) + (COUNT_W+1)'(len24);

  always_comb begin
    priority if (cnt_inc < COUNT_W'(HEADER_BYTES)) status = ST_TRUNCATED;
    else if (frame_err != ST_OK)                   status = frame_err;
    else if ({1'b0, cnt_inc} != total)             status = ST_MISMATCH;
    else                                           status = ST_OK;
  end

  always_comb begin
    hdr_item                 = '0;
    hdr_item.item_kind       = KIND_HEADER;
    hdr_item.direction       = dir;
    hdr_item.request_id_high = id_high;
    hdr_item.request_id_low  = id_low;
    hdr_item.sequence_number = seq;
    hdr_item.payload_length  = len24;

    pay_item                 = '0;
    pay_item.item_kind       = KIND_PAYLOAD;
    pay_item.payload_byte    = in_item.frame_byte;

    st_item                  = '0;
    st_item.item_kind        = KIND_STATUS;
    st_item.status_code      = status;
    st_item.frame_done       = 1'b1;
  end

  // When a byte yields both a header or payload result and a status result, the
  // status result follows the other one.
  always_comb begin
    push       = '0;
    push.item0 = st_item;
    push.item1 = st_item;
    if (take) begin
      if (hdr_out || pay_ok) begin
        push.item0 = hdr_out ? hdr_item : pay_item;
        push.count = in_item.end_of_frame ? 2'd2 : 2'd1;
      end else begin
        push.count = in_item.end_of_frame ? 2'd1 : 2'd0;
      end
    end
  end

  always_comb begin
    byte_count_nxt   = byte_count_r;
    first_error_nxt  = first_error_r;
    header_valid_nxt = header_valid_r;
    if (take) begin
      byte_count_nxt = cnt_inc;
      if (last_hdr) begin
        first_error_nxt  = hdr_err;
        header_valid_nxt = hdr_out;
      end
      if (in_item.end_of_frame) begin
        byte_count_nxt   = '0;
        first_error_nxt  = ST_OK;
        header_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r   <= '0;
      first_error_r  <= ST_OK;
      header_valid_r <= 1'b0;
      max_payload_r  <= MAX_PAYLOAD_RESET;
      dir_input_r    <= DIR_INPUT_RESET;
      dir_output_r   <= DIR_OUTPUT_RESET;
    end else begin
      byte_count_r   <= byte_count_nxt;
      first_error_r  <= first_error_nxt;
      header_valid_r <= header_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_PAYLOAD: max_payload_r <= cfg_wdata;
          CFG_DIR_INPUT:   dir_input_r   <= cfg_wdata[15:0];
          CFG_DIR_OUTPUT:  dir_output_r  <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end

  // Header bytes are written once per frame; older contents are never read
  // before being overwritten.
  always_ff @(posedge clk) begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      if (take && pos == COUNT_W'(i)) begin
        hdr_r[i] <= in_item.frame_byte;
      end
    end
  end

endmodule

### rtl/tdf_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdf_out_fifo
// Result queue that takes up to two results per cycle and delivers one.
// ----------------------------------------------------------------------------
module tdf_out_fifo import tdf_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  res_push_t push,
  input  logic      pop,
  output logic      not_empty,
  output logic      has_room,
  output out_item_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign not_empty = count_r != '0;
  // Room for the two results one byte may produce.
  assign has_room  = count_r <= CNT_W'(DEPTH - 2);
  assign head      = mem_r[rd_ptr_r];
  assign wr_ptr_p1 = wr_ptr_r + PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.count);
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.item0;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.item1;
    end
  end

endmodule

### rtl/terminal_frame_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_frame_deframer_core
// Results enter the result queue with their byte's transaction, and out_valid shows
// the queue head. Throughput: one byte per cycle while the queue has room, set by
// the byte counter and header check path; a byte's two results leave one at a
// time. Reset clears the frame state and result queue and loads register defaults.
// ----------------------------------------------------------------------------
module terminal_frame_deframer_core import tdf_pkg::*; #(
  parameter int OUT_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic      take, has_room;
  res_push_t push;

  assign in_ready = has_room;
  assign take     = in_valid && has_room;

  tdf_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .in_item  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .push     (push)
  );

  tdf_out_fifo #(
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (out_valid && out_ready),
    .not_empty(out_valid),
    .has_room (has_room),
    .head     (out_data)
  );

endmodule
